FILE: rtl/tensor_layout_hwcn_to_nchw_top_defines.svh
// Assertion macros for the HWCN to NCHW layout reorder block.
// Used by the top level; depends on nothing else.
`ifndef TENSOR_LAYOUT_HWCN_TO_NCHW_TOP_DEFINES_SVH
`define TENSOR_LAYOUT_HWCN_TO_NCHW_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define TLH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define TLH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tlh_pkg.sv
// Shared types, codes and sizes for the HWCN to NCHW layout reorder block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tlh_pkg;

    // Tensor buffer depth in words and the address width it needs.
    localparam int STORE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Field and register widths.
    localparam int DIM_W     = 13;
    localparam int POS_W     = 12;
    localparam int WORD_W    = 32;
    localparam int RIDX_W    = 12;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int PROD_W    = 4 * DIM_W;
    localparam int HALF_W    = 2 * DIM_W;
    localparam int CFG_IDX_W = 3;

    // Cycles the address and product pipeline needs after its inputs change.
    localparam logic [1:0] SETTLE_CYCLES = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_N      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_C      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_H      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_W      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEM_COUNT = 3'd4;

    // Command codes of an input item.
    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_RANGE    = 2'd2
    } status_t;

    // Tensor dimensions and expected element count.
    typedef struct packed {
        logic [DIM_W-1:0] n;
        logic [DIM_W-1:0] c;
        logic [DIM_W-1:0] h;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] count;
    } dims_t;

    // Running load position.
    typedef struct packed {
        logic [POS_W-1:0] n;
        logic [POS_W-1:0] c;
        logic [POS_W-1:0] h;
        logic [POS_W-1:0] w;
    } pos_t;

    // Checks derived from the dimension product.
    typedef struct packed {
        logic             mismatch;
        logic             zero;
        logic             fits;
        logic [DIM_W-1:0] prod_lo;
    } prod_flags_t;

endpackage

`default_nettype wire

FILE: rtl/tlh_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// Standalone; no package dependency.
`default_nettype none

module tlh_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One access per cycle: a write, or a read whose data is held until the next read.
    always_ff @(posedge clk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tlh_addr_unit.sv
// Three-stage pipeline for the NCHW store address and the dimension product checks.
// Depends on tlh_pkg.
`default_nettype none

module tlh_addr_unit (
    input  wire logic                         aclk,
    input  wire tlh_pkg::dims_t               dims,
    input  wire tlh_pkg::pos_t                pos,
    output logic [tlh_pkg::ADDR_W-1:0]        addr,
    output tlh_pkg::prod_flags_t              flags
);

    localparam int AW = tlh_pkg::ADDR_W;

    logic [tlh_pkg::HALF_W-1:0] nc_reg;
    logic [tlh_pkg::HALF_W-1:0] hw_reg;
    logic [tlh_pkg::PROD_W-1:0] prod_reg;
    logic [AW-1:0]              t1_reg;
    logic [AW-1:0]              t2_reg;
    logic [AW-1:0]              addr_reg;
    tlh_pkg::prod_flags_t       flags_reg;
    tlh_pkg::prod_flags_t       flags_next;

    // The product is below 2^13 only when the upper bits are clear.
    always_comb begin
        flags_next.fits     = (prod_reg[tlh_pkg::PROD_W-1:tlh_pkg::DIM_W] == '0);
        flags_next.prod_lo  = prod_reg[tlh_pkg::DIM_W-1:0];
        flags_next.zero     = (prod_reg == '0);
        flags_next.mismatch = !flags_next.fits
                           || (flags_next.prod_lo != dims.count)
                           || (prod_reg > tlh_pkg::PROD_W'(tlh_pkg::STORE_DEPTH));
    end

    // Address arithmetic is modulo the buffer size; an accepted write's address
    // is below the product, so nothing is lost by truncation.
    always_ff @(posedge aclk) begin
        nc_reg    <= tlh_pkg::HALF_W'(dims.n) * tlh_pkg::HALF_W'(dims.c);
        hw_reg    <= tlh_pkg::HALF_W'(dims.h) * tlh_pkg::HALF_W'(dims.w);
        t1_reg    <= AW'(AW'(pos.n) * AW'(dims.c) + AW'(pos.c));
        prod_reg  <= tlh_pkg::PROD_W'(nc_reg) * tlh_pkg::PROD_W'(hw_reg);
        t2_reg    <= AW'(t1_reg * AW'(dims.h) + AW'(pos.h));
        flags_reg <= flags_next;
        addr_reg  <= AW'(t2_reg * AW'(dims.w) + AW'(pos.w));
    end

    assign addr  = addr_reg;
    assign flags = flags_reg;

endmodule

`default_nettype wire

FILE: rtl/tensor_layout_hwcn_to_nchw_top.sv
// A result item is valid in the cycle after its input item is accepted.
// Throughput: reads and refused writes run one item per cycle while the result channel
// is ready; a stored write or a restart holds off the next item until the multiply
// pipeline that recomputes the NCHW address has settled; a register write does too.
// Reset: registers to 1, load counters and done flag to zero, no result pending; the store
// is not cleared, and input is held off after reset until the address pipeline settles.
`default_nettype none
`include "tensor_layout_hwcn_to_nchw_top_defines.svh"

module tensor_layout_hwcn_to_nchw_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Configuration write port.
    input  wire logic                            cfg_wr_en,
    input  wire logic [tlh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tlh_pkg::DIM_W-1:0]       cfg_wdata,
    // Input channel.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [47:0]                     s_tdata,  // value[31:0], read_index[43:32]
    input  wire logic [tlh_pkg::CMD_W-1:0]       s_tuser,  // command[1:0]
    // Result channel.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [39:0]                          m_tdata   // read_value[31:0], status[33:32]
);

    localparam int AW = tlh_pkg::ADDR_W;

    tlh_pkg::dims_t                 dims_reg, dims_next;
    tlh_pkg::pos_t                  pos_reg, pos_next;
    logic                           done_reg, done_next;
    logic [1:0]                     settle_reg, settle_next;
    logic                           m_valid_reg, m_valid_next;
    tlh_pkg::status_t               rsp_status_reg, status_comb;
    logic                           rsp_read_reg;

    logic [AW-1:0]                  calc_addr;
    tlh_pkg::prod_flags_t           flags;
    logic [tlh_pkg::WORD_W-1:0]     rdata;

    logic                           accept;
    logic [tlh_pkg::CMD_W-1:0]      cmd;
    logic [tlh_pkg::WORD_W-1:0]     value;
    logic [tlh_pkg::RIDX_W-1:0]     ridx;
    logic                           pos_ok, write_ok, read_ok;
    logic                           do_store, do_read, do_restart;
    logic [tlh_pkg::POS_W:0]        n_inc, c_inc, h_inc, w_inc;
    logic                           ram_en;
    logic [AW-1:0]                  ram_addr;

    assign cmd   = s_tuser;
    assign value = s_tdata[31:0];
    assign ridx  = s_tdata[43:32];

    // An item enters once the pipeline has settled and the result slot frees up.
    assign s_tready = (settle_reg == 2'd0) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    tlh_addr_unit u_addr (
        .aclk  (aclk),
        .dims  (dims_reg),
        .pos   (pos_reg),
        .addr  (calc_addr),
        .flags (flags)
    );

    // Write and read checks.
    always_comb begin
        pos_ok   = ({1'b0, pos_reg.n} < dims_reg.n) && ({1'b0, pos_reg.c} < dims_reg.c)
                && ({1'b0, pos_reg.h} < dims_reg.h) && ({1'b0, pos_reg.w} < dims_reg.w);
        write_ok = !flags.mismatch && !done_reg && !flags.zero && pos_ok;
        read_ok  = (int'(ridx) < tlh_pkg::STORE_DEPTH)
                && (!flags.fits || ({1'b0, ridx} < flags.prod_lo));
    end

    // Command decode and result status.
    always_comb begin
        do_store    = 1'b0;
        do_read     = 1'b0;
        do_restart  = 1'b0;
        status_comb = tlh_pkg::ST_OK;
        unique case (cmd)
            tlh_pkg::CMD_WRITE: begin
                do_store = write_ok;
                if (flags.mismatch) begin
                    status_comb = tlh_pkg::ST_MISMATCH;
                end else if (!write_ok) begin
                    status_comb = tlh_pkg::ST_RANGE;
                end
            end
            tlh_pkg::CMD_READ: begin
                do_read = read_ok;
                if (!read_ok) begin
                    status_comb = tlh_pkg::ST_RANGE;
                end
            end
            tlh_pkg::CMD_RESTART: begin
                do_restart = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Load counters: n fastest, then c, then w, then h.
    always_comb begin
        pos_next  = pos_reg;
        done_next = done_reg;
        n_inc     = {1'b0, pos_reg.n} + 1'b1;
        c_inc     = {1'b0, pos_reg.c} + 1'b1;
        w_inc     = {1'b0, pos_reg.w} + 1'b1;
        h_inc     = {1'b0, pos_reg.h} + 1'b1;
        if (accept && do_restart) begin
            pos_next  = '0;
            done_next = 1'b0;
        end else if (accept && do_store) begin
            if (n_inc < dims_reg.n) begin
                pos_next.n = n_inc[tlh_pkg::POS_W-1:0];
            end else begin
                pos_next.n = '0;
                if (c_inc < dims_reg.c) begin
                    pos_next.c = c_inc[tlh_pkg::POS_W-1:0];
                end else begin
                    pos_next.c = '0;
                    if (w_inc < dims_reg.w) begin
                        pos_next.w = w_inc[tlh_pkg::POS_W-1:0];
                    end else begin
                        pos_next.w = '0;
                        if (h_inc < dims_reg.h) begin
                            pos_next.h = h_inc[tlh_pkg::POS_W-1:0];
                        end else begin
                            pos_next.h = '0;
                            done_next  = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // Configuration registers; indexes beyond the list are ignored.
    always_comb begin
        dims_next = dims_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                tlh_pkg::CFG_DIM_N:      dims_next.n     = cfg_wdata;
                tlh_pkg::CFG_DIM_C:      dims_next.c     = cfg_wdata;
                tlh_pkg::CFG_DIM_H:      dims_next.h     = cfg_wdata;
                tlh_pkg::CFG_DIM_W:      dims_next.w     = cfg_wdata;
                tlh_pkg::CFG_ELEM_COUNT: dims_next.count = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Hold-off counter: restarts whenever the pipeline inputs change.
    always_comb begin
        if (cfg_wr_en || (accept && (do_store || do_restart))) begin
            settle_next = tlh_pkg::SETTLE_CYCLES;
        end else if (settle_reg != 2'd0) begin
            settle_next = settle_reg - 2'd1;
        end else begin
            settle_next = settle_reg;
        end
    end

    // Result slot occupancy.
    always_comb begin
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg    <= '{n: 13'd1, c: 13'd1, h: 13'd1, w: 13'd1, count: 13'd1};
            pos_reg     <= '0;
            done_reg    <= 1'b0;
            settle_reg  <= tlh_pkg::SETTLE_CYCLES;
            m_valid_reg <= 1'b0;
        end else begin
            dims_reg    <= dims_next;
            pos_reg     <= pos_next;
            done_reg    <= done_next;
            settle_reg  <= settle_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload, captured with the item.
    always_ff @(posedge aclk) begin
        if (accept) begin
            rsp_status_reg <= status_comb;
            rsp_read_reg   <= do_read;
        end
    end

    // Tensor store: writes go to the computed NCHW address, reads to the index given.
    assign ram_en   = accept && (do_store || do_read);
    assign ram_addr = do_store ? calc_addr : AW'(ridx);

    tlh_ram #(
        .DEPTH (tlh_pkg::STORE_DEPTH),
        .WIDTH (tlh_pkg::WORD_W)
    ) u_store (
        .clk   (aclk),
        .en    (ram_en),
        .we    (do_store),
        .addr  (ram_addr),
        .wdata (value),
        .rdata (rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, rsp_status_reg, (rsp_read_reg ? rdata : '0)};

    // A stored write must restart the hold-off so the next address is fresh.
    `TLH_ASSERT_NEXT(a_store_settles, aclk, aresetn, accept && do_store,
        settle_reg == tlh_pkg::SETTLE_CYCLES, "stored write did not restart hold-off")
    // Every accepted item leaves a result pending in the next cycle.
    `TLH_ASSERT_NEXT(a_accept_result, aclk, aresetn, accept, m_valid_reg,
        "accepted item produced no result")
    // After a register write the input stays closed while the pipeline refills.
    `TLH_ASSERT_NEXT(a_cfg_holds_input, aclk, aresetn, cfg_wr_en, !s_tready,
        "input accepted right after a register write")

endmodule

`default_nettype wire
